// ===== hw/rtl/mutf8_pkg.sv =====
// Shared types and constants for the modified UTF-8 decoder.
package mutf8_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned SLOT_COUNT  = 2;

   localparam logic [2:0] LEAD_TWO_BYTE   = 3'b110;
   localparam logic [1:0] CONT_TAG        = 2'b10;
   localparam logic [3:0] LEAD_THREE_BYTE = 4'b1110;
   localparam logic [5:0] HIGH_SURR_TAG   = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG    = 6'b110111;
   localparam logic [20:0] SUPPL_BASE     = 21'h10000;

   typedef enum logic [1:0] {
      PH_LEAD        = 2'd0,
      PH_TWO_LAST    = 2'd1,
      PH_THREE_MID   = 2'd2,
      PH_THREE_LAST  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        has_char;
      logic        bad_sequence;
      logic        string_end;
      logic        run_last;
   } result_type;

   localparam result_type RESULT_NONE = '{
      code_point: 21'd0, has_char: 1'b0, bad_sequence: 1'b0,
      string_end: 1'b0, run_last: 1'b0};

endpackage

// ===== hw/rtl/modified_utf8_decoder.sv =====
// Top level of the modified UTF-8 decoder: byte decoder and result queue.
//
// Decodes a Java modified UTF-8 byte stream into Unicode code points. One request byte
// is accepted per clock cycle whenever the four-entry result queue has room for two
// results; the byte is decoded against the sequence state in the same cycle and its
// zero, one or two results enter the queue together. Results leave the queue at one per
// cycle while rsp_tready is high, so a stream sustains one byte per cycle while most
// bytes yield at most one result, and the output port sets the pace when bytes yield
// two. Surrogate pairs are joined, C0 80 is dropped, bad or truncated sequences give an
// error result, and a string's final byte always yields at least one result with tlast.
module modified_utf8_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [21] run_last, [23:22] zero
   output logic [1:0]  rsp_tuser,   // [0] has_char, [1] bad_sequence
   output logic        rsp_tlast    // string_end
);

   localparam int unsigned AW = mutf8_pkg::QUEUE_AW;

   mutf8_pkg::phase_type phase_ff, phase_in;
   logic [9:0]  partial_ff, partial_in;
   logic [9:0]  held_ff, held_in;
   logic        held_valid_ff, held_valid_in;

   mutf8_pkg::result_type queue_ff [mutf8_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   mutf8_pkg::result_type slot [mutf8_pkg::SLOT_COUNT];
   logic [1:0]  n_push;
   logic        req_accept;
   logic        rsp_accept;

   assign req_tready = (count_ff <= (AW+1)'(mutf8_pkg::QUEUE_DEPTH - mutf8_pkg::SLOT_COUNT));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   always_comb begin
      logic [7:0]  b;
      logic        cont;
      logic        have;
      logic        err;
      logic        drop;
      logic [15:0] v;
      logic        is_hi;
      logic        is_lo;
      logic [9:0]  held_mid;
      logic        held_mid_valid;
      mutf8_pkg::result_type item;
      b    = req_tdata;
      cont = (b[7:6] == mutf8_pkg::CONT_TAG);
      have = 1'b0;
      err  = 1'b0;
      drop = 1'b0;
      v    = 16'd0;
      phase_in   = mutf8_pkg::PH_LEAD;
      partial_in = partial_ff;
      case (phase_ff)
         mutf8_pkg::PH_TWO_LAST: begin
            if (cont) begin
               v = {5'd0, partial_ff[4:0], b[5:0]};
               drop = (v == 16'd0);
               have = (v != 16'd0);
            end else begin
               err = 1'b1;
            end
         end
         mutf8_pkg::PH_THREE_MID: begin
            if (cont) begin
               partial_in = {partial_ff[3:0], b[5:0]};
               phase_in = mutf8_pkg::PH_THREE_LAST;
            end else begin
               err = 1'b1;
            end
         end
         mutf8_pkg::PH_THREE_LAST: begin
            if (cont) begin
               v = {partial_ff, b[5:0]};
               have = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         default: begin
            if (!b[7]) begin
               v = {8'd0, b};
               have = 1'b1;
            end else if (b[7:5] == mutf8_pkg::LEAD_TWO_BYTE) begin
               partial_in = {5'd0, b[4:0]};
               phase_in = mutf8_pkg::PH_TWO_LAST;
            end else if (b[7:4] == mutf8_pkg::LEAD_THREE_BYTE) begin
               partial_in = {6'd0, b[3:0]};
               phase_in = mutf8_pkg::PH_THREE_MID;
            end else begin
               err = 1'b1;
            end
         end
      endcase

      is_hi = have && (v[15:10] == mutf8_pkg::HIGH_SURR_TAG);
      is_lo = have && (v[15:10] == mutf8_pkg::LOW_SURR_TAG);

      slot[0] = mutf8_pkg::RESULT_NONE;
      slot[1] = mutf8_pkg::RESULT_NONE;
      n_push  = 2'd0;
      held_mid       = held_ff;
      held_mid_valid = held_valid_ff;

      item = mutf8_pkg::RESULT_NONE;
      item.code_point = {5'd0, mutf8_pkg::HIGH_SURR_TAG, held_ff};
      item.has_char = 1'b1;
      if (held_valid_ff && (have || err || drop) && !is_lo) begin
         slot[n_push[0]] = item;
         n_push = n_push + 2'd1;
         held_mid_valid = 1'b0;
      end

      item = mutf8_pkg::RESULT_NONE;
      if (is_hi) begin
         held_mid = v[9:0];
         held_mid_valid = 1'b1;
      end else if (is_lo && held_valid_ff) begin
         item.code_point = mutf8_pkg::SUPPL_BASE + {1'b0, held_ff, v[9:0]};
         item.has_char = 1'b1;
         slot[n_push[0]] = item;
         n_push = n_push + 2'd1;
         held_mid_valid = 1'b0;
      end else if (have) begin
         item.code_point = {5'd0, v};
         item.has_char = 1'b1;
         slot[n_push[0]] = item;
         n_push = n_push + 2'd1;
      end else if (err) begin
         item.bad_sequence = 1'b1;
         slot[n_push[0]] = item;
         n_push = n_push + 2'd1;
      end

      held_in       = held_mid;
      held_valid_in = held_mid_valid;

      if (req_tlast) begin
         item = mutf8_pkg::RESULT_NONE;
         if (held_mid_valid) begin
            item.code_point = {5'd0, mutf8_pkg::HIGH_SURR_TAG, held_mid};
            item.has_char = 1'b1;
            slot[n_push[0]] = item;
            n_push = n_push + 2'd1;
         end
         item = mutf8_pkg::RESULT_NONE;
         if (phase_in != mutf8_pkg::PH_LEAD) begin
            item.bad_sequence = 1'b1;
            slot[n_push[0]] = item;
            n_push = n_push + 2'd1;
         end
         if (n_push == 2'd0) begin
            slot[0] = mutf8_pkg::RESULT_NONE;
            n_push = 2'd1;
         end
         phase_in      = mutf8_pkg::PH_LEAD;
         partial_in    = 10'd0;
         held_in       = 10'd0;
         held_valid_in = 1'b0;
      end

      if (n_push == 2'd2) begin
         slot[1].run_last = 1'b1;
         slot[1].string_end = req_tlast;
      end else if (n_push == 2'd1) begin
         slot[0].run_last = 1'b1;
         slot[0].string_end = req_tlast;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_accept) begin
         wr_ptr_in = wr_ptr_ff + AW'(n_push);
         count_in  = count_ff + (AW+1)'(n_push);
      end
      if (rsp_accept) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
         count_in  = count_in - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= mutf8_pkg::PH_LEAD;
         partial_ff    <= 10'd0;
         held_ff       <= 10'd0;
         held_valid_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (req_accept) begin
            phase_ff      <= phase_in;
            partial_ff    <= partial_in;
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (n_push != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= slot[0];
      end
      if (req_accept && (n_push == 2'd2)) begin
         queue_ff[wr_ptr_ff + AW'(1)] <= slot[1];
      end
   end

   assign rsp_tdata = {2'b00, queue_ff[rd_ptr_ff].run_last, queue_ff[rd_ptr_ff].code_point};
   assign rsp_tuser = {queue_ff[rd_ptr_ff].bad_sequence, queue_ff[rd_ptr_ff].has_char};
   assign rsp_tlast = queue_ff[rd_ptr_ff].string_end;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(mutf8_pkg::QUEUE_DEPTH))
      else $error("Result queue count exceeds its depth.");

   a_final_clears_state: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> (phase_ff == mutf8_pkg::PH_LEAD) && !held_valid_ff)
      else $error("Sequence state not cleared after the final byte.");

   a_final_has_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |-> n_push != 2'd0)
      else $error("Final byte produced no result.");

   a_push_bound: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> n_push <= 2'd2)
      else $error("A request produced more than two results.");

endmodule
